// File: rtl/core/assert_macros.svh
// Assertion macros shared by the converter RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define PCMC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pcmc check failed");

// Clocked check that also holds during reset.
`define PCMC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("pcmc check failed");

`endif

// File: rtl/core/pcmc_pkg.sv
// Shared constants for the PCM format and rate converter.
// No dependencies; used by the channel interfaces and the top level.
package pcmc_pkg;

  localparam int FRAME_BITS    = 24;
  localparam int FRAC_BITS     = 16;
  localparam int POS_BITS      = FRAME_BITS + FRAC_BITS;
  localparam int RAW_BITS      = 32;
  localparam int SAMPLE_BITS   = 16;
  localparam int STEP_BITS     = 24;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_INPUT_FORMAT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_MONO_INPUT   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RATE_STEP    = 2'd2;

  // input format codes
  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_16 = 2'd1;
  localparam logic [1:0] FMT_24 = 2'd2;
  localparam logic [1:0] FMT_32 = 2'd3;

  localparam logic [1:0]           RESET_FORMAT = FMT_16;
  localparam logic [STEP_BITS-1:0] RESET_STEP   = STEP_BITS'(1) << FRAC_BITS;
  localparam logic [STEP_BITS-1:0] MIN_STEP     = STEP_BITS'(1) << (FRAC_BITS - 6);

  typedef logic [RAW_BITS-1:0]           raw_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

endpackage

// File: rtl/core/pcmc_in_if.sv
// Input channel: one PCM frame per item, valid/ready handshake.
// Depends on pcmc_pkg.
interface pcmc_in_if import pcmc_pkg::*; ();
  logic valid;
  logic ready;
  raw_t left_raw;
  raw_t right_raw;
  logic last_frame;

  modport source (output valid, output left_raw, output right_raw, output last_frame,
                  input ready);
  modport sink   (input valid, input left_raw, input right_raw, input last_frame,
                  output ready);
endinterface

// File: rtl/core/pcmc_out_if.sv
// Output channel: one stereo 16-bit sample pair per item, valid/ready handshake.
// Depends on pcmc_pkg.
interface pcmc_out_if import pcmc_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t left_sample;
  sample_t right_sample;
  logic    last_of_run;

  modport source (output valid, output left_sample, output right_sample,
                  output last_of_run, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input last_of_run, output ready);
endinterface

// File: rtl/core/pcm_format_and_rate_converter.sv
// PCM format and rate converter top level.
// Depends on pcmc_pkg, pcmc_in_if, pcmc_out_if and assert_macros.svh.
//
// Each input item is one PCM frame. It is converted to two signed 16-bit samples
// (8-bit x255, 16-bit as is, 24-bit /256 and 32-bit /65535, toward zero, saturated)
// by one shared conversion unit, left then right (mono converts left only and
// copies it to right). A single phase adder then advances the 24.16 position once
// per cycle and emits one stereo result per cycle while the position stays on this
// frame and the output is not stalled. frame_in.ready stays low from acceptance
// through the conversion and emit states, so a new frame is taken only after the
// last result of the one before is loaded for output; at most 64 results per frame.
// frame_in.ready is high only between frames. The last frame of a buffer emits only
// results whose step stays within it, and returns the position and frame count to
// zero.
`include "assert_macros.svh"

module pcm_format_and_rate_converter import pcmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  pcmc_in_if.sink                  frame_in,
  pcmc_out_if.source               sample_out
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_CONV_L = 2'd1;
  localparam logic [1:0] ST_CONV_R = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  function automatic sample_t to_sample16(input raw_t raw, input logic [1:0] fmt);
    logic signed [16:0] x8;
    logic signed [16:0] s8;
    logic [23:0]        m24;
    logic [RAW_BITS-1:0] m32;
    logic [15:0]        q0;
    logic [16:0]        r;
    logic [16:0]        qmag;
    logic               neg;
    logic signed [17:0] v;
    sample_t            res;
    x8   = {{9{raw[7]}}, raw[7:0]};
    s8   = (x8 <<< 8) - x8;
    m24  = raw[23] ? (~raw[23:0] + 24'd1) : raw[23:0];
    m32  = raw[31] ? (~raw + 32'd1) : raw;
    q0   = m32[31:16];
    r    = {1'b0, m32[15:0]} + {1'b0, q0};
    qmag = 17'd0;
    neg  = 1'b0;
    v    = 18'sd0;
    case (fmt)
      FMT_8: begin
        v = {s8[16], s8};
      end
      FMT_16: begin
        v = {{2{raw[15]}}, raw[15:0]};
      end
      FMT_24: begin
        neg  = raw[23];
        qmag = {1'b0, m24[23:8]};
        v    = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      end
      default: begin
        neg  = raw[31];
        qmag = {1'b0, q0} + ((r >= 17'd65535) ? 17'd1 : 17'd0);
        v    = neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
      end
    endcase
    if (v > 18'sd32767) begin
      res = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

  logic [1:0]           input_format;
  logic                 mono_input;
  logic [STEP_BITS-1:0] rate_step;

  logic [1:0]            state;
  logic [POS_BITS-1:0]   pick_position;
  logic [FRAME_BITS-1:0] frame_index;
  raw_t                  left_raw_r;
  raw_t                  right_raw_r;
  logic                  last_r;
  sample_t               left_s;
  sample_t               right_s;
  logic                  have_one;

  logic    out_valid;
  sample_t out_left;
  sample_t out_right;
  logic    out_last;

  logic [STEP_BITS-1:0] step_eff;
  logic [STEP_BITS:0]   frac_sum;
  logic                 on_frame;
  logic                 emit_ok;
  logic                 out_free;
  logic                 out_load;
  raw_t                 conv_raw;
  sample_t              conv_out;

  assign step_eff = (rate_step < MIN_STEP) ? MIN_STEP : rate_step;
  assign frac_sum = (STEP_BITS+1)'(pick_position[FRAC_BITS-1:0]) + {1'b0, step_eff};
  assign on_frame = (pick_position[POS_BITS-1:FRAC_BITS] == frame_index);
  assign emit_ok  = on_frame &&
                    !(last_r && (frac_sum > ((STEP_BITS+1)'(1) << FRAC_BITS)));
  assign out_free = !out_valid || sample_out.ready;
  assign out_load = (state == ST_EMIT) && out_free && have_one;

  // shared conversion unit
  assign conv_raw = (state == ST_CONV_R) ? right_raw_r : left_raw_r;
  assign conv_out = to_sample16(conv_raw, input_format);

  assign frame_in.ready          = (state == ST_IDLE);
  assign sample_out.valid        = out_valid;
  assign sample_out.left_sample  = out_left;
  assign sample_out.right_sample = out_right;
  assign sample_out.last_of_run  = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format <= RESET_FORMAT;
      mono_input   <= 1'b0;
      rate_step    <= RESET_STEP;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INPUT_FORMAT: input_format <= cfg_data[1:0];
        REG_MONO_INPUT:   mono_input   <= cfg_data[0];
        REG_RATE_STEP:    rate_step    <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (frame_in.valid && frame_in.ready) begin
      left_raw_r  <= frame_in.left_raw;
      right_raw_r <= frame_in.right_raw;
      last_r      <= frame_in.last_frame;
    end
    if (state == ST_CONV_L) begin
      left_s <= conv_out;
      if (mono_input) begin
        right_s <= conv_out;
      end
    end
    if (state == ST_CONV_R) begin
      right_s <= conv_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      pick_position <= '0;
      frame_index   <= '0;
      have_one      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (sample_out.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (frame_in.valid) begin
            state <= ST_CONV_L;
          end
        end
        ST_CONV_L: begin
          state <= mono_input ? ST_EMIT : ST_CONV_R;
        end
        ST_CONV_R: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          // one result is held back until we know whether another follows
          if (out_free) begin
            if (emit_ok) begin
              pick_position <= pick_position + POS_BITS'(step_eff);
              have_one      <= 1'b1;
              if (have_one) begin
                out_valid <= 1'b1;
                out_left  <= left_s;
                out_right <= right_s;
                out_last  <= 1'b0;
              end
            end else begin
              if (have_one) begin
                out_valid <= 1'b1;
                out_left  <= left_s;
                out_right <= right_s;
                out_last  <= 1'b1;
              end
              have_one <= 1'b0;
              state    <= ST_IDLE;
              if (last_r) begin
                pick_position <= '0;
                frame_index   <= '0;
              end else begin
                frame_index <= frame_index + FRAME_BITS'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PCMC_ASSERT(a_accept_starts_conv, clk, rst,
    frame_in.valid && frame_in.ready |=> state == ST_CONV_L)
  `PCMC_ASSERT(a_run_closes_with_last, clk, rst,
    state == ST_EMIT && out_free && !emit_ok && have_one
      |=> sample_out.valid && sample_out.last_of_run && state == ST_IDLE)
  `PCMC_ASSERT(a_mono_pair_equal, clk, rst,
    sample_out.valid && mono_input |-> sample_out.left_sample == sample_out.right_sample)
  `PCMC_ASSERT(a_buffer_end_clears, clk, rst,
    state == ST_EMIT && out_free && !emit_ok && last_r
      |=> pick_position == '0 && frame_index == '0)
  `PCMC_ASSERT_ALWAYS(a_no_hold_when_idle, clk,
    state == ST_IDLE |-> !have_one)

endmodule
